// ----- sv/tcd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the tile change detector.
// Used by tcd_cfg and tile_change_detector; depends on nothing.
package tcd_pkg;

  localparam int unsigned DEF_TILE_COLUMNS     = 64;
  localparam int unsigned DEF_TILE_ROWS        = 64;
  localparam int unsigned DEF_MAX_FRAME_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_FRAME_HEIGHT = 4096;

  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned CFG_VALUE_W  = 13;
  localparam int unsigned CFG_RESET_SZ = 64;

  localparam int unsigned PIXEL_W      = 32;
  localparam int unsigned HASH_W       = 64;
  localparam int unsigned HASH_SHIFT   = 5;
  localparam int unsigned TILE_IDX_W   = 12;
  localparam int unsigned COUNT_W      = 13;
  localparam int unsigned OUT_TDATA_W  = 96;

  localparam int unsigned OUT_QUEUE_DEPTH = 4;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [TILE_IDX_W-1:0] tile_num;
    logic                  tile_changed;
    logic [HASH_W-1:0]     tile_hash;
    logic                  frame_last;
    logic [COUNT_W-1:0]    changed_count;
  } out_item_t;

endpackage

// ----- sv/tcd_cfg.sv -----
`timescale 1ns / 1ps
// APB register file of the tile change detector: frame size and derived tile size.
// Depends on tcd_pkg.
module tcd_cfg #(
  parameter int unsigned TILE_COLUMNS     = tcd_pkg::DEF_TILE_COLUMNS,
  parameter int unsigned TILE_ROWS        = tcd_pkg::DEF_TILE_ROWS,
  parameter int unsigned MAX_FRAME_WIDTH  = tcd_pkg::DEF_MAX_FRAME_WIDTH,
  parameter int unsigned MAX_FRAME_HEIGHT = tcd_pkg::DEF_MAX_FRAME_HEIGHT,
  localparam int unsigned FW_W = $clog2(MAX_FRAME_WIDTH + 1),
  localparam int unsigned FH_W = $clog2(MAX_FRAME_HEIGHT + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [tcd_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [tcd_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [tcd_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready,
  output logic [FW_W-1:0]                 frame_width,
  output logic [FW_W-1:0]                 tile_width,
  output logic [FH_W-1:0]                 tile_height
);

  // Tile size is frame size times a rounded-up reciprocal, exact over the field range.
  localparam int unsigned WD_SHIFT = FW_W + 7;
  localparam int unsigned WD_RW    = WD_SHIFT + 1;
  localparam int unsigned WD_PW    = FW_W + WD_RW;
  localparam logic [WD_RW-1:0] WD_RECIP =
    WD_RW'((2**WD_SHIFT + TILE_COLUMNS - 1) / TILE_COLUMNS);
  localparam int unsigned HD_SHIFT = FH_W + 7;
  localparam int unsigned HD_RW    = HD_SHIFT + 1;
  localparam int unsigned HD_PW    = FH_W + HD_RW;
  localparam logic [HD_RW-1:0] HD_RECIP =
    HD_RW'((2**HD_SHIFT + TILE_ROWS - 1) / TILE_ROWS);

  localparam logic [FW_W-1:0] RST_FW = FW_W'(tcd_pkg::CFG_RESET_SZ);
  localparam logic [FH_W-1:0] RST_FH = FH_W'(tcd_pkg::CFG_RESET_SZ);
  localparam logic [FW_W-1:0] RST_TW = FW_W'(tcd_pkg::CFG_RESET_SZ / TILE_COLUMNS);
  localparam logic [FH_W-1:0] RST_TH = FH_W'(tcd_pkg::CFG_RESET_SZ / TILE_ROWS);

  logic [FW_W-1:0] fw_r, tw_r;
  logic [FH_W-1:0] fh_r, th_r;

  logic [tcd_pkg::CFG_VALUE_W-1:0] wval;
  logic [FW_W-1:0]                 fw_nxt, tw_nxt;
  logic [FH_W-1:0]                 fh_nxt, th_nxt;
  logic [WD_PW-1:0]                wprod;
  logic [HD_PW-1:0]                hprod;
  logic                            wr_en;
  tcd_pkg::cfg_reg_t               reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = tcd_pkg::cfg_reg_t'(cfg_paddr[2]);
  assign wval       = cfg_pwdata[tcd_pkg::CFG_VALUE_W-1:0];

  always_comb begin
    fw_nxt = (32'(wval) > MAX_FRAME_WIDTH) ? FW_W'(MAX_FRAME_WIDTH) : FW_W'(wval);
    fh_nxt = (32'(wval) > MAX_FRAME_HEIGHT) ? FH_W'(MAX_FRAME_HEIGHT) : FH_W'(wval);
    wprod  = WD_PW'(fw_nxt) * WD_PW'(WD_RECIP);
    hprod  = HD_PW'(fh_nxt) * HD_PW'(HD_RECIP);
    tw_nxt = wprod[WD_SHIFT +: FW_W];
    th_nxt = hprod[HD_SHIFT +: FH_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= RST_FW;
      fh_r <= RST_FH;
      tw_r <= RST_TW;
      th_r <= RST_TH;
    end else if (wr_en) begin
      unique case (reg_sel)
        tcd_pkg::REG_FRAME_WIDTH: begin
          fw_r <= fw_nxt;
          tw_r <= tw_nxt;
        end
        tcd_pkg::REG_FRAME_HEIGHT: begin
          fh_r <= fh_nxt;
          th_r <= th_nxt;
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      tcd_pkg::REG_FRAME_WIDTH:  cfg_prdata = tcd_pkg::CFG_DATA_W'(fw_r);
      tcd_pkg::REG_FRAME_HEIGHT: cfg_prdata = tcd_pkg::CFG_DATA_W'(fh_r);
    endcase
  end

  assign frame_width  = fw_r;
  assign tile_width   = tw_r;
  assign tile_height  = th_r;

endmodule

// ----- sv/tile_change_detector.sv -----
`timescale 1ns / 1ps
// Top level of the tile change detector: position counters, hash memories, result queue.
// Depends on tcd_pkg and tcd_cfg.
//
// The block takes one pixel per clock cycle in raster order while in_tready is high and
// keeps a times-33 hash for each tile of the grid. A result goes from the hash stage
// into a four-entry queue, so the input keeps moving while a result waits, until the
// queue fills. The rate of one pixel per cycle is set by the single read port of the
// running-hash and stored-hash memories, each read once per pixel and written in the
// next cycle, with the written value forwarded. After reset the stored-hash memory
// is zeroed by a clearing pass over all TILE_COLUMNS * TILE_ROWS entries (4096 by
// default) during which in_tready is low; register writes are taken during that pass.
module tile_change_detector #(
  parameter int unsigned TILE_COLUMNS     = tcd_pkg::DEF_TILE_COLUMNS,
  parameter int unsigned TILE_ROWS        = tcd_pkg::DEF_TILE_ROWS,
  parameter int unsigned MAX_FRAME_WIDTH  = tcd_pkg::DEF_MAX_FRAME_WIDTH,
  parameter int unsigned MAX_FRAME_HEIGHT = tcd_pkg::DEF_MAX_FRAME_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // pixel_value
  input  logic [tcd_pkg::PIXEL_W-1:0]       in_tdata,
  // frame_start
  input  logic                              in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tile number, tile_hash, changed_count, zero padding
  output logic [tcd_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // tile_changed
  output logic                              out_tuser,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [tcd_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [tcd_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [tcd_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  localparam int unsigned FW_W       = $clog2(MAX_FRAME_WIDTH + 1);
  localparam int unsigned FH_W       = $clog2(MAX_FRAME_HEIGHT + 1);
  localparam int unsigned CC_W       = $clog2(TILE_COLUMNS + 1);
  localparam int unsigned CR_W       = $clog2(TILE_ROWS + 1);
  localparam int unsigned RC_W       = (TILE_COLUMNS > 1) ? $clog2(TILE_COLUMNS) : 1;
  localparam int unsigned TILE_TOTAL = TILE_COLUMNS * TILE_ROWS;
  localparam int unsigned IDX_W      = (TILE_TOTAL > 1) ? $clog2(TILE_TOTAL) : 1;
  localparam int unsigned HW         = tcd_pkg::HASH_W;
  localparam int unsigned QD         = tcd_pkg::OUT_QUEUE_DEPTH;
  localparam int unsigned QP_W       = $clog2(QD);
  localparam int unsigned QC_W       = $clog2(QD + 1);
  localparam int unsigned CNT_W      = tcd_pkg::COUNT_W;

  logic [FW_W-1:0] frame_width, tile_width;
  logic [FH_W-1:0] tile_height;

  tcd_cfg #(
    .TILE_COLUMNS    (TILE_COLUMNS),
    .TILE_ROWS       (TILE_ROWS),
    .MAX_FRAME_WIDTH (MAX_FRAME_WIDTH),
    .MAX_FRAME_HEIGHT(MAX_FRAME_HEIGHT)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .frame_width (frame_width),
    .tile_width  (tile_width),
    .tile_height (tile_height)
  );

  // Position counters.
  logic [FW_W-1:0] pc_r, cit_r;
  logic [FH_W-1:0] rit_r;
  logic [CC_W-1:0] ctc_r;
  logic [CR_W-1:0] ctr_r;
  logic [FW_W-1:0] pc_nxt, cit_nxt, b_pc, b_cit;
  logic [FH_W-1:0] rit_nxt, b_rit;
  logic [CC_W-1:0] ctc_nxt, b_ctc;
  logic [CR_W-1:0] ctr_nxt, b_ctr;

  // Intake stage.
  logic             acc;
  logic             s0_active, s0_first, s0_last;
  logic [IDX_W-1:0] s0_idx;
  logic [RC_W-1:0]  s0_col;
  logic             s0_fwd_run, s0_fwd_st, s0_run_ok;

  // Hash stage.
  logic                        s1_valid_r;
  logic [tcd_pkg::PIXEL_W-1:0] s1_pix_r;
  logic                        s1_start_r, s1_active_r, s1_first_r, s1_last_r;
  logic [IDX_W-1:0]            s1_idx_r;
  logic [RC_W-1:0]             s1_col_r;
  logic                        s1_fwd_run_r, s1_fwd_st_r, s1_run_ok_r;
  logic [HW-1:0]               hold_h_r;
  logic [HW-1:0]               h_prev, s1_h, st_prev;
  logic                        s1_wr, s1_res, s1_changed;
  logic [CNT_W-1:0]            tally_r, tally_base, tally_nxt;

  // Memories.
  logic [HW-1:0]   run_mem [TILE_COLUMNS];
  logic [HW-1:0]   run_rdata_r;
  logic            run_valid_r [TILE_COLUMNS];
  logic [HW-1:0]   st_mem [TILE_TOTAL];
  logic [HW-1:0]   st_rdata_r;
  logic            st_we;
  logic [IDX_W-1:0] st_waddr;
  logic [HW-1:0]   st_wdata;
  logic            clearing_r;
  logic [IDX_W-1:0] clr_addr_r;

  // Result queue.
  tcd_pkg::out_item_t q_r [QD];
  tcd_pkg::out_item_t q_in, q_head;
  logic [QP_W-1:0]   q_wp_r, q_rp_r;
  logic [QC_W-1:0]   q_cnt_r;
  logic [QC_W:0]     q_need;
  logic              q_pop;

  assign q_need    = (QC_W+1)'(q_cnt_r) + (QC_W+1)'(s1_res);
  assign in_tready = !clearing_r && (q_need < (QC_W+1)'(QD));
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    b_pc  = in_tuser ? '0 : pc_r;
    b_cit = in_tuser ? '0 : cit_r;
    b_rit = in_tuser ? '0 : rit_r;
    b_ctc = in_tuser ? '0 : ctc_r;
    b_ctr = in_tuser ? '0 : ctr_r;

    s0_active = (tile_width != '0) && (tile_height != '0) &&
                (b_ctc < CC_W'(TILE_COLUMNS)) && (b_ctr < CR_W'(TILE_ROWS));
    s0_first  = (b_cit == '0) && (b_rit == '0);
    s0_last   = ((FW_W+1)'(b_cit) + 1'b1 == (FW_W+1)'(tile_width)) &&
                ((FH_W+1)'(b_rit) + 1'b1 == (FH_W+1)'(tile_height));
    s0_idx    = IDX_W'(32'(b_ctr) * TILE_COLUMNS + 32'(b_ctc));
    s0_col    = b_ctc[RC_W-1:0];

    s0_fwd_run = s1_valid_r && s1_active_r && (s1_col_r == s0_col);
    s0_fwd_st  = s1_valid_r && s1_active_r && s1_last_r && (s1_idx_r == s0_idx);
    s0_run_ok  = run_valid_r[s0_col] || s0_fwd_run;

    pc_nxt  = b_pc;
    cit_nxt = b_cit;
    rit_nxt = b_rit;
    ctc_nxt = b_ctc;
    ctr_nxt = b_ctr;
    if ((FW_W+1)'(b_pc) + 1'b1 >= (FW_W+1)'(frame_width)) begin
      pc_nxt  = '0;
      cit_nxt = '0;
      ctc_nxt = '0;
      if (b_ctr < CR_W'(TILE_ROWS)) begin
        if ((FH_W+1)'(b_rit) + 1'b1 >= (FH_W+1)'(tile_height)) begin
          rit_nxt = '0;
          ctr_nxt = b_ctr + 1'b1;
        end else begin
          rit_nxt = b_rit + 1'b1;
        end
      end
    end else begin
      pc_nxt = b_pc + 1'b1;
      if (b_ctc < CC_W'(TILE_COLUMNS)) begin
        if ((FW_W+1)'(b_cit) + 1'b1 >= (FW_W+1)'(tile_width)) begin
          cit_nxt = '0;
          ctc_nxt = b_ctc + 1'b1;
        end else begin
          cit_nxt = b_cit + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r       <= '0;
      cit_r      <= '0;
      rit_r      <= '0;
      ctc_r      <= '0;
      ctr_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= acc;
      if (acc) begin
        pc_r  <= pc_nxt;
        cit_r <= cit_nxt;
        rit_r <= rit_nxt;
        ctc_r <= ctc_nxt;
        ctr_r <= ctr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r     <= in_tdata;
      s1_start_r   <= in_tuser;
      s1_active_r  <= s0_active;
      s1_first_r   <= s0_first;
      s1_last_r    <= s0_last;
      s1_idx_r     <= s0_idx;
      s1_col_r     <= s0_col;
      s1_fwd_run_r <= s0_fwd_run;
      s1_fwd_st_r  <= s0_fwd_st;
      s1_run_ok_r  <= s0_run_ok;
    end
  end

  // Hash update: h * 33 + pixel as a shift-add.
  always_comb begin
    if (s1_first_r || !s1_run_ok_r) begin
      h_prev = '0;
    end else if (s1_fwd_run_r) begin
      h_prev = hold_h_r;
    end else begin
      h_prev = run_rdata_r;
    end
    s1_h       = (h_prev << tcd_pkg::HASH_SHIFT) + h_prev + HW'(s1_pix_r);
    st_prev    = s1_fwd_st_r ? hold_h_r : st_rdata_r;
    s1_wr      = s1_valid_r && s1_active_r;
    s1_res     = s1_wr && s1_last_r;
    s1_changed = (st_prev != s1_h);
    tally_base = s1_start_r ? '0 : tally_r;
    tally_nxt  = tally_base;
    if (s1_res && s1_changed && (tally_base != '1)) begin
      tally_nxt = tally_base + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r <= '0;
      for (int i = 0; i < TILE_COLUMNS; i++) begin
        run_valid_r[i] <= 1'b0;
      end
    end else begin
      if (s1_valid_r) begin
        tally_r <= tally_nxt;
      end
      if (s1_wr) begin
        run_valid_r[s1_col_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      hold_h_r <= s1_h;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      run_mem[s1_col_r] <= s1_h;
    end
    run_rdata_r <= run_mem[s0_col];
  end

  assign st_we    = clearing_r || s1_res;
  assign st_waddr = clearing_r ? clr_addr_r : s1_idx_r;
  assign st_wdata = clearing_r ? '0 : s1_h;

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_rdata_r <= st_mem[s0_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == IDX_W'(TILE_TOTAL - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_comb begin
    q_in.tile_num      = tcd_pkg::TILE_IDX_W'(s1_idx_r);
    q_in.tile_changed  = s1_changed;
    q_in.tile_hash     = s1_h;
    q_in.frame_last    = (s1_idx_r == IDX_W'(TILE_TOTAL - 1));
    q_in.changed_count = tally_nxt;
  end

  assign q_pop  = out_tvalid && out_tready;
  assign q_head = q_r[q_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= '0;
      q_rp_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (s1_res) begin
        q_wp_r <= q_wp_r + 1'b1;
      end
      if (q_pop) begin
        q_rp_r <= q_rp_r + 1'b1;
      end
      q_cnt_r <= q_cnt_r + QC_W'(s1_res) - QC_W'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_res) begin
      q_r[q_wp_r] <= q_in;
    end
  end

  assign out_tvalid = (q_cnt_r != '0);
  assign out_tuser  = q_head.tile_changed;
  assign out_tlast  = q_head.frame_last;
  assign out_tdata  = {{(tcd_pkg::OUT_TDATA_W - tcd_pkg::TILE_IDX_W - HW - CNT_W){1'b0}},
                       q_head.changed_count, q_head.tile_hash, q_head.tile_num};

endmodule
